// ===== sv/ffa_pkg.sv =====
`default_nettype none

package ffa_pkg;

  localparam int SIZE_W   = 16;
  localparam int ADDR_W   = 16;
  localparam int LIMIT_W  = 17;
  localparam int BREAK_W  = 17;
  localparam int NEED_W   = 18;
  localparam int STATUS_W = 3;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                used;
    logic [SIZE_W-1:0]   length;
    logic [ADDR_W-1:0]   start;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic load;
    logic scan;
    logic take_null;
    logic take_hit;
    logic take_miss;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic req_null;
    logic hit;
    logic scan_end;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// ===== sv/ffa_ram.sv =====
`default_nettype none

module ffa_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/ffa_ctrl.sv =====
`default_nettype none

module ffa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  output ffa_pkg::ctrl_cmd_t      cmd,
  input  wire ffa_pkg::ctrl_sts_t sts
);

  import ffa_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (sts.req_null) begin
          cmd.take_null = 1'b1;
          state_nxt     = S_DONE;
        end else if (sts.hit) begin
          cmd.take_hit = 1'b1;
          state_nxt    = S_DONE;
        end else if (sts.scan_end) begin
          cmd.take_miss = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/ffa_dp.sv =====
`default_nettype none

module ffa_dp #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 24,
  parameter int HEAP_BYTES   = 65536
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [31:0]                       in_tdata,
  input  wire logic                              in_tuser,
  input  wire logic                              cfg_we,
  input  wire logic [ffa_pkg::LIMIT_W-1:0]       cfg_wdata,
  input  wire logic                              out_tready,
  output logic                                   out_tvalid,
  output logic [15:0]                            out_tdata,
  output logic [ffa_pkg::STATUS_W-1:0]           out_tuser,
  input  wire ffa_pkg::ctrl_cmd_t                cmd,
  output ffa_pkg::ctrl_sts_t                     sts
);

  import ffa_pkg::*;

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  logic [LIMIT_W-1:0]  heap_limit_r;
  logic [BREAK_W-1:0]  heap_break_r;
  logic [CNT_W-1:0]    block_count_r;
  logic                func_r;
  logic [SIZE_W-1:0]   size_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [CNT_W-1:0]    idx_r;
  logic                rd_vld_r;
  logic [IDX_W-1:0]    rd_idx_r;
  logic [STATUS_W-1:0] res_status_r;
  logic [ADDR_W-1:0]   res_addr_r;
  logic                out_vld_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ADDR_W-1:0]   out_addr_r;

  entry_t              rd_entry;
  entry_t              wr_entry;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic                ram_re;
  logic                match;
  logic [LIMIT_W-1:0]  eff_limit;
  logic [NEED_W-1:0]   base;
  logic [NEED_W-1:0]   need;
  logic                exhausted;
  logic                table_full;
  logic                append_ok;

  assign rd_entry = entry_t'(ram_rdata);

  always_comb begin
    if (func_r == FUNC_ALLOC) begin
      match = !rd_entry.used && (rd_entry.length >= size_r);
    end else begin
      match = (rd_entry.start == addr_r);
    end
  end

  assign eff_limit  = (heap_limit_r > LIMIT_W'(HEAP_BYTES)) ? LIMIT_W'(HEAP_BYTES)
                                                             : heap_limit_r;
  assign base       = NEED_W'(heap_break_r) + NEED_W'(HEADER_BYTES);
  assign need       = base + NEED_W'(size_r);
  assign exhausted  = need > NEED_W'(eff_limit);
  assign table_full = block_count_r >= CNT_W'(MAX_BLOCKS);
  assign append_ok  = (func_r == FUNC_ALLOC) && !exhausted && !table_full;

  assign sts.req_null = (func_r == FUNC_ALLOC) ? (size_r == '0) : (addr_r == '0);
  assign sts.hit      = rd_vld_r && match;
  assign sts.scan_end = !rd_vld_r && (idx_r >= block_count_r);
  assign sts.out_free = !out_vld_r || out_tready;

  // hit sets used on the entry read (free clears it); a fitting miss appends an entry at break + header
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = block_count_r[IDX_W-1:0];
    wr_entry  = rd_entry;
    if (cmd.take_hit) begin
      ram_we        = 1'b1;
      ram_waddr     = rd_idx_r;
      wr_entry.used = (func_r == FUNC_ALLOC);
    end else if (cmd.take_miss && append_ok) begin
      ram_we          = 1'b1;
      wr_entry.used   = 1'b1;
      wr_entry.length = size_r;
      wr_entry.start  = base[ADDR_W-1:0];
    end
  end

  assign ram_re = cmd.scan && (idx_r < block_count_r);

  ffa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_limit_r  <= LIMIT_W'(65536);
      heap_break_r  <= '0;
      block_count_r <= '0;
      rd_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        heap_limit_r <= cfg_wdata;
      end
      if (cmd.load) begin
        rd_vld_r <= 1'b0;
      end else if (cmd.scan) begin
        rd_vld_r <= ram_re;
      end
      if (cmd.take_miss && append_ok) begin
        block_count_r <= block_count_r + CNT_W'(1);
        heap_break_r  <= need[BREAK_W-1:0];
      end
      if (cmd.emit) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_tuser;
      size_r <= in_tdata[15:0];
      addr_r <= in_tdata[31:16];
      idx_r  <= '0;
    end else if (ram_re) begin
      idx_r    <= idx_r + CNT_W'(1);
      rd_idx_r <= idx_r[IDX_W-1:0];
    end
    if (cmd.take_null) begin
      res_status_r <= ST_NULL;
      res_addr_r   <= '0;
    end else if (cmd.take_hit) begin
      res_status_r <= ST_OK;
      res_addr_r   <= (func_r == FUNC_ALLOC) ? rd_entry.start : '0;
    end else if (cmd.take_miss) begin
      res_addr_r <= '0;
      priority if (func_r == FUNC_FREE) begin
        res_status_r <= ST_NOT_FOUND;
      end else if (exhausted) begin
        res_status_r <= ST_EXHAUSTED;
      end else if (table_full) begin
        res_status_r <= ST_FULL;
      end else begin
        res_status_r <= ST_OK;
        res_addr_r   <= base[ADDR_W-1:0];
      end
    end
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_status_r;

endmodule

`default_nettype wire

// ===== sv/first_fit_block_allocator_top.sv =====
// channel  direction  tdata                                       tuser
// in       slave      [15:0] request_size, [31:16] address         [0] func
// out      master     [15:0] data_address                          [2:0] status
// cfg      write      cfg_wdata[16:0] heap_limit                   -
//
// an item is loaded in idle, then table entries are read one a cycle up to and
// including a match (all block_count entries when none matches, none for a null
// request or an empty table); the result then waits for the output register
// reset clears block count, heap break and the handshakes; table contents are
// left as they are and only entries below the count are ever read
// a result waits in the output register while the next transaction is taken

`default_nettype none

module first_fit_block_allocator_top #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 24,
  parameter int HEAP_BYTES   = 65536
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [31:0]                 in_tdata,  // request_size, address
  input  wire logic                        in_tuser,  // func
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [15:0]                      out_tdata, // data_address
  output logic [ffa_pkg::STATUS_W-1:0]     out_tuser, // status
  input  wire logic                        cfg_we,
  input  wire logic [ffa_pkg::LIMIT_W-1:0] cfg_wdata
);

  import ffa_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  ffa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ffa_dp #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES),
    .HEAP_BYTES   (HEAP_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.take_null, cmd.take_hit, cmd.take_miss}))
    else $error("more than one outcome chosen for one transaction");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result overwrites one not yet taken");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("new transaction taken while one is in progress");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_tvalid)
    else $error("emitted result not presented");

endmodule

`default_nettype wire
